FILE: hw/rtl/infix_calc_stream_unit_macros.svh
// Assertion macros for the checker of the calculator.
`ifndef INFIX_CALC_STREAM_UNIT_MACROS_SVH
`define INFIX_CALC_STREAM_UNIT_MACROS_SVH

// Same-cycle implication, held off while reset is applied.
`define ICS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is applied.
`define ICS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ics_pkg.sv
package ics_pkg;

    localparam int TOTAL_WIDTH = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FINISH,
        ST_WAIT,
        ST_POST,
        ST_EMIT
    } calc_state_t;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV,
        ALU_FIX
    } alu_state_t;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_MUL,
        PEND_DIV
    } pend_t;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_PLUS,
        CLS_MINUS,
        CLS_MUL,
        CLS_DIV
    } char_class_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_sts_t;

endpackage

FILE: hw/rtl/infix_calc_stream_unit.sv
// Streaming infix calculator. Each input word is one ASCII character of an
// expression made of unsigned decimal numbers, spaces and the operators + - * /
// (any other non-digit code counts as /); * and / bind tighter than + and -.
// The word flagged s_is_last closes the expression and produces one result
// word: the value wrapped to VALUE_WIDTH bits, given as its low 32 bits, and a
// sticky flag for any division by zero (which yields 0). Division truncates
// toward zero. A digit, or a space that ends no number, stays in ST_IDLE
// unless it is the last character. A space that ends a number, or an
// operator, passes through ST_FINISH and ST_POST, and through ST_WAIT as
// well when it closes the right operand of a pending * or /, since that
// operation runs one bit per cycle through the shared shift-and-add
// multiplier and restoring divider (a division by zero is flagged without
// stepping through them). The last character is followed by one more operand
// close, through ST_FINISH and, with a pending operation, ST_WAIT, and then
// ST_EMIT loads the output register. A result waiting in the output register
// does not stop further characters; only the next result waits.
module infix_calc_stream_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_char_code,
    input  logic                            s_is_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ics_pkg::TOTAL_WIDTH-1:0] m_total,
    output logic                            m_div_zero
);

    localparam int TW = ics_pkg::TOTAL_WIDTH;

    ics_pkg::calc_state_t st_reg, st_next;
    ics_pkg::char_class_t cls_reg, cls_next;
    ics_pkg::pend_t       pend_reg, pend_next;
    logic                   final_reg, final_next;
    logic                   last_reg, last_next;
    logic [VALUE_WIDTH-1:0] sum_reg, sum_next;
    logic [VALUE_WIDTH-1:0] term_reg, term_next;
    logic [VALUE_WIDTH-1:0] num_reg, num_next;
    logic                   in_num_reg, in_num_next;
    logic                   minus_reg, minus_next;
    logic                   derr_reg, derr_next;
    logic                   m_valid_reg, m_valid_next;
    logic [TW-1:0]          m_total_reg, m_total_next;
    logic                   m_dz_reg, m_dz_next;

    ics_pkg::alu_req_t      alu_req;
    ics_pkg::alu_sts_t      alu_sts;
    logic [VALUE_WIDTH-1:0] alu_result;

    logic                   is_digit;
    logic [VALUE_WIDTH-1:0] num_x10;
    logic [VALUE_WIDTH-1:0] fold;
    ics_pkg::calc_state_t   after_st;

    ics_serial_alu #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_alu (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (alu_req),
        .op_a   (term_reg),
        .op_b   (num_reg),
        .sts    (alu_sts),
        .result (alu_result)
    );

    assign is_digit = (s_char_code >= ics_pkg::CHAR_ZERO) && (s_char_code <= ics_pkg::CHAR_NINE);
    // Ten times the number as two shifted copies; the digit is the low nibble.
    assign num_x10  = (num_reg << 3) + (num_reg << 1) + VALUE_WIDTH'(s_char_code[3:0]);
    assign fold     = minus_reg ? (sum_reg - term_reg) : (sum_reg + term_reg);
    assign after_st = final_reg ? ics_pkg::ST_EMIT : ics_pkg::ST_POST;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ics_pkg::ST_IDLE;
            final_reg   <= 1'b0;
            pend_reg    <= ics_pkg::PEND_NONE;
            sum_reg     <= '0;
            term_reg    <= '0;
            num_reg     <= '0;
            in_num_reg  <= 1'b0;
            minus_reg   <= 1'b0;
            derr_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            final_reg   <= final_next;
            pend_reg    <= pend_next;
            sum_reg     <= sum_next;
            term_reg    <= term_next;
            num_reg     <= num_next;
            in_num_reg  <= in_num_next;
            minus_reg   <= minus_next;
            derr_reg    <= derr_next;
            m_valid_reg <= m_valid_next;
        end
        cls_reg     <= cls_next;
        last_reg    <= last_next;
        m_total_reg <= m_total_next;
        m_dz_reg    <= m_dz_next;
    end

    always_comb begin
        st_next        = st_reg;
        cls_next       = cls_reg;
        pend_next      = pend_reg;
        final_next     = final_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        term_next      = term_reg;
        num_next       = num_reg;
        in_num_next    = in_num_reg;
        minus_next     = minus_reg;
        derr_next      = derr_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_total_next   = m_total_reg;
        m_dz_next      = m_dz_reg;
        alu_req.start  = 1'b0;
        alu_req.is_div = (pend_reg == ics_pkg::PEND_DIV);
        unique case (st_reg)
            ics_pkg::ST_IDLE: begin
                if (s_valid) begin
                    last_next  = s_is_last;
                    final_next = 1'b0;
                    if (is_digit) begin
                        num_next    = num_x10;
                        in_num_next = 1'b1;
                        if (s_is_last) begin
                            final_next = 1'b1;
                            st_next    = ics_pkg::ST_FINISH;
                        end
                    end else if (s_char_code == ics_pkg::CHAR_SPACE) begin
                        cls_next = ics_pkg::CLS_SPACE;
                        // A space only matters when it closes a number or the expression.
                        if (in_num_reg) begin
                            st_next = ics_pkg::ST_FINISH;
                        end else if (s_is_last) begin
                            final_next = 1'b1;
                            st_next    = ics_pkg::ST_FINISH;
                        end
                    end else begin
                        if (s_char_code == ics_pkg::CHAR_PLUS) begin
                            cls_next = ics_pkg::CLS_PLUS;
                        end else if (s_char_code == ics_pkg::CHAR_MINUS) begin
                            cls_next = ics_pkg::CLS_MINUS;
                        end else if (s_char_code == ics_pkg::CHAR_STAR) begin
                            cls_next = ics_pkg::CLS_MUL;
                        end else begin
                            cls_next = ics_pkg::CLS_DIV;
                        end
                        st_next = ics_pkg::ST_FINISH;
                    end
                end
            end
            ics_pkg::ST_FINISH: begin
                // Close the current operand; a missing right operand reads as zero.
                if (pend_reg == ics_pkg::PEND_NONE) begin
                    if (in_num_reg) begin
                        term_next   = num_reg;
                        num_next    = '0;
                        in_num_next = 1'b0;
                    end
                    st_next = after_st;
                end else begin
                    alu_req.start = 1'b1;
                    st_next       = ics_pkg::ST_WAIT;
                end
            end
            ics_pkg::ST_WAIT: begin
                if (alu_sts.done) begin
                    term_next   = alu_result;
                    derr_next   = derr_reg | alu_sts.div_zero;
                    pend_next   = ics_pkg::PEND_NONE;
                    num_next    = '0;
                    in_num_next = 1'b0;
                    st_next     = after_st;
                end
            end
            ics_pkg::ST_POST: begin
                case (cls_reg)
                    ics_pkg::CLS_PLUS, ics_pkg::CLS_MINUS: begin
                        sum_next   = fold;
                        term_next  = '0;
                        minus_next = (cls_reg == ics_pkg::CLS_MINUS);
                    end
                    ics_pkg::CLS_MUL: begin
                        pend_next = ics_pkg::PEND_MUL;
                    end
                    ics_pkg::CLS_DIV: begin
                        pend_next = ics_pkg::PEND_DIV;
                    end
                    default: begin
                    end
                endcase
                if (last_reg) begin
                    final_next = 1'b1;
                    st_next    = ics_pkg::ST_FINISH;
                end else begin
                    st_next = ics_pkg::ST_IDLE;
                end
            end
            ics_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_total_next = TW'(fold);
                    m_dz_next    = derr_reg;
                    sum_next     = '0;
                    term_next    = '0;
                    num_next     = '0;
                    in_num_next  = 1'b0;
                    minus_next   = 1'b0;
                    pend_next    = ics_pkg::PEND_NONE;
                    derr_next    = 1'b0;
                    final_next   = 1'b0;
                    st_next      = ics_pkg::ST_IDLE;
                end
            end
            default: begin
                st_next = ics_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready    = (st_reg == ics_pkg::ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_total    = m_total_reg;
    assign m_div_zero = m_dz_reg;

endmodule

FILE: hw/rtl/ics_serial_alu.sv
module ics_serial_alu #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ics_pkg::alu_req_t      req,
    input  logic [VALUE_WIDTH-1:0] op_a,
    input  logic [VALUE_WIDTH-1:0] op_b,
    output ics_pkg::alu_sts_t      sts,
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int CW = $clog2(VALUE_WIDTH);

    ics_pkg::alu_state_t state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    // Product while multiplying, partial remainder while dividing.
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    // Multiplicand, or dividend shifting out as quotient bits shift in.
    logic [VALUE_WIDTH-1:0] opx_reg, opx_next;
    // Multiplier shifting right, or the divisor magnitude.
    logic [VALUE_WIDTH-1:0] opy_reg, opy_next;
    logic                   neg_reg, neg_next;
    logic                   done_reg, done_next;
    logic                   dz_reg, dz_next;
    logic [VALUE_WIDTH-1:0] result_reg, result_next;

    logic                   a_neg;
    logic                   b_neg;
    logic [VALUE_WIDTH-1:0] mag_a;
    logic [VALUE_WIDTH-1:0] mag_b;
    logic [VALUE_WIDTH-1:0] prod_sum;
    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   diff;
    logic                   fits;
    logic                   last_step;

    assign a_neg     = op_a[VALUE_WIDTH-1];
    assign b_neg     = op_b[VALUE_WIDTH-1];
    assign mag_a     = a_neg ? (VALUE_WIDTH'(0) - op_a) : op_a;
    assign mag_b     = b_neg ? (VALUE_WIDTH'(0) - op_b) : op_b;
    assign prod_sum  = acc_reg + opx_reg;
    assign rem_shift = {acc_reg, opx_reg[VALUE_WIDTH-1]};
    assign diff      = rem_shift - {1'b0, opy_reg};
    assign fits      = !diff[VALUE_WIDTH];
    assign last_step = (cnt_reg == CW'(VALUE_WIDTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ics_pkg::ALU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        opx_reg    <= opx_next;
        opy_reg    <= opy_next;
        neg_reg    <= neg_next;
        dz_reg     <= dz_next;
        result_reg <= result_next;
    end

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        opx_next    = opx_reg;
        opy_next    = opy_reg;
        neg_next    = neg_reg;
        dz_next     = dz_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            ics_pkg::ALU_IDLE: begin
                if (req.start) begin
                    cnt_next = '0;
                    acc_next = '0;
                    dz_next  = 1'b0;
                    if (!req.is_div) begin
                        opx_next   = op_a;
                        opy_next   = op_b;
                        state_next = ics_pkg::ALU_MUL;
                    end else if (mag_b == '0) begin
                        result_next = '0;
                        dz_next     = 1'b1;
                        done_next   = 1'b1;
                    end else begin
                        opx_next   = mag_a;
                        opy_next   = mag_b;
                        neg_next   = a_neg ^ b_neg;
                        state_next = ics_pkg::ALU_DIV;
                    end
                end
            end
            ics_pkg::ALU_MUL: begin
                if (opy_reg[0]) begin
                    acc_next = prod_sum;
                end
                opx_next = opx_reg << 1;
                opy_next = opy_reg >> 1;
                cnt_next = cnt_reg + CW'(1);
                if (last_step) begin
                    result_next = opy_reg[0] ? prod_sum : acc_reg;
                    done_next   = 1'b1;
                    state_next  = ics_pkg::ALU_IDLE;
                end
            end
            ics_pkg::ALU_DIV: begin
                // The partial remainder stays below the divisor, so its top bit is always clear.
                acc_next = fits ? diff[VALUE_WIDTH-1:0] : rem_shift[VALUE_WIDTH-1:0];
                opx_next = {opx_reg[VALUE_WIDTH-2:0], fits};
                cnt_next = cnt_reg + CW'(1);
                if (last_step) begin
                    state_next = ics_pkg::ALU_FIX;
                end
            end
            ics_pkg::ALU_FIX: begin
                // The most negative value over minus one wraps back onto itself here.
                result_next = neg_reg ? (VALUE_WIDTH'(0) - opx_reg) : opx_reg;
                done_next   = 1'b1;
                state_next  = ics_pkg::ALU_IDLE;
            end
            default: begin
                state_next = ics_pkg::ALU_IDLE;
            end
        endcase
    end

    assign sts.done     = done_reg;
    assign sts.div_zero = dz_reg;
    assign result       = result_reg;

endmodule

FILE: hw/rtl/ics_port_checker.sv
`include "infix_calc_stream_unit_macros.svh"

module ics_port_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [7:0]                      s_char_code,
    input logic                            s_is_last,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [ics_pkg::TOTAL_WIDTH-1:0] m_total,
    input logic                            m_div_zero
);

    logic in_take;
    logic in_digit;

    assign in_take  = s_valid && s_ready;
    assign in_digit = (s_char_code >= ics_pkg::CHAR_ZERO) && (s_char_code <= ics_pkg::CHAR_NINE);

    `ICS_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable(m_total) && $stable(m_div_zero), "result word changed while stalled")

    `ICS_ASSERT_NEXT(a_no_early_result, in_take && !s_is_last && !m_valid, !m_valid, "result word appeared before the closing character")

    `ICS_ASSERT_NEXT(a_busy_after_last, in_take && s_is_last, !s_ready, "closing character did not hold off the input")

    `ICS_ASSERT_NEXT(a_digit_one_cycle, in_take && !s_is_last && in_digit, s_ready, "a digit took more than one cycle")

endmodule

bind infix_calc_stream_unit ics_port_checker u_port_checker (.*);
